/* rtl/sst_pkg.sv */
// Shared types and constants for the sorted set successor table.
`timescale 1ns / 1ps

package sst_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] successor_value;
        logic [2:0]  status;
        logic [4:0]  entry_count;
    } t_out_item;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        ins;
        logic        rem;
        logic [31:0] value;
    } t_cell_ctl;

    // Compare results that each cell reports.
    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

/* rtl/sorted_set_successor_table.sv */
// Top level of the sorted set successor table: cell chain, command decode and result register.
`timescale 1ns / 1ps

// Channel     Direction  Handshake               Payload
// command     in         start, busy             i_item   (cmd, item_value)
// result      out        o_done (one-cycle)      o_result (successor_value, status, entry_count)
//
// For every command, the whole cell chain compares against the value and shifts
// in the same clock edge that accepts the transaction, and the result appears on
// o_result with o_done high in the following cycle. busy is never raised,
// so a new transaction may be started in every cycle. Synchronous active-low reset
// empties the set; stored values themselves are not cleared, since only cells below
// the entry count are ever looked at. The receiver cannot stall the result.

module sorted_set_successor_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sst_pkg::t_in_item  i_item,
    output logic               o_done,
    output sst_pkg::t_out_item o_result
);
    import sst_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_out_item        r_result;
    t_out_item        n_result;

    logic             accept;
    logic             found;
    logic             full;
    logic             empty;
    logic [31:0]      succ;
    t_cell_ctl        ctl;

    t_cell_flags      flags [CAPACITY];
    logic [31:0]      vals  [CAPACITY];
    logic             gt    [CAPACITY];

    // The chain updates in the same cycle that it compares, so it is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            found = found | flags[i].eq;
        end
    end

    // Insert only when the value is new and room remains; remove only a stored value.
    assign ctl.value = i_item.item_value;
    assign ctl.ins   = accept && (i_item.cmd == CMD_INSERT) && !found && !full;
    assign ctl.rem   = accept && (i_item.cmd == CMD_REMOVE) && found;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic        live;
        logic        left_lt;
        logic [31:0] left_val;
        logic [31:0] right_val;

        assign live = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_lt  = 1'b1;
            assign left_val = vals[g];
        end else begin : g_mid
            assign left_lt  = flags[g-1].lt;
            assign left_val = vals[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = vals[g];
        end else begin : g_inner
            assign right_val = vals[g+1];
        end

        // A stored value above the query value; the first such cell is the successor.
        assign gt[g] = live && !flags[g].lt && !flags[g].eq;

        sst_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_live      (live),
            .i_left_lt   (left_lt),
            .i_left_val  (left_val),
            .i_right_val (right_val),
            .o_flags     (flags[g]),
            .o_val       (vals[g])
        );
    end

    // The stored values are ascending, so the greater-than flags form a run and
    // exactly one cell starts it when a successor exists.
    always_comb begin
        succ = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (gt[i] && (i == 0 || !gt[(i == 0) ? 0 : i - 1])) begin
                succ = succ | vals[i];
            end
        end
    end

    always_comb begin
        n_count                  = r_count;
        n_result.successor_value = '0;
        n_result.status          = ST_OK;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (ctl.rem) begin
            n_count = r_count - 1'b1;
        end
        unique case (i_item.cmd)
            CMD_INSERT: begin
                if (found) begin
                    n_result.status = ST_DUP;
                end else if (full) begin
                    n_result.status = ST_FULL;
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    n_result.status = ST_EMPTY;
                end else if (!found) begin
                    n_result.status = ST_NOTFOUND;
                end
            end
            CMD_QUERY: begin
                n_result.successor_value = succ;
            end
            default: begin
                n_result.status = ST_OK;
            end
        endcase
        n_result.entry_count = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef SYNTHESIS
    // Every accepted transaction produces its result in the next cycle.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted command produced no result");

    // No result appears without a command in the previous cycle.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_done)
        else $error("result without a command");

    // The set never grows past its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // One command moves the count by at most one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1)
                    || (r_count == $past(r_count) - 1'b1))
        else $error("entry count jumped");

    // A refused insert is reported only when the set is full.
    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> full)
        else $error("insert refused while room remained");
`endif

endmodule

/* rtl/sst_cell.sv */
// One storage cell of the sorted chain: holds a value and shifts with its neighbors.
`timescale 1ns / 1ps

module sst_cell (
    input  logic                i_clk,
    input  sst_pkg::t_cell_ctl  i_ctl,
    input  logic                i_live,
    input  logic                i_left_lt,
    input  logic [31:0]         i_left_val,
    input  logic [31:0]         i_right_val,
    output sst_pkg::t_cell_flags o_flags,
    output logic [31:0]         o_val
);
    import sst_pkg::*;

    logic [31:0] r_val;
    logic [31:0] n_val;

    assign o_flags.lt = i_live && (r_val < i_ctl.value);
    assign o_flags.eq = i_live && (r_val == i_ctl.value);
    assign o_val      = r_val;

    // Cells below the insert or remove point keep their value; the rest move by one.
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !o_flags.lt) begin
            n_val = i_left_lt ? i_ctl.value : i_left_val;
        end else if (i_ctl.rem && !o_flags.lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

/* tb/sv/tb_sorted_set_successor_table.sv */
// Self-checking testbench for the sorted set successor table.
`timescale 1ns / 1ps

module tb_sorted_set_successor_table;

    import sst_pkg::*;

    // The package names no code for the spare command value, so the bench names it here.
    // The block must answer it with a zero successor, an ok status and the current count.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int POOL_SIZE = 24;

    // Clock, reset and the command side are known from time zero.
    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    t_in_item   i_item  = '0;
    logic       busy;
    logic       o_done;
    t_out_item  o_result;

    // The bench's own copy of the set: ascending values and the number of valid entries.
    logic [31:0] set_vals [CAPACITY];
    int          set_count = 0;
    int          peak_count = 0;

    // Results the block still owes, oldest first.
    t_out_item   pending_results [$];

    // Values that the random traffic keeps coming back to, so that duplicates,
    // hits on remove and near misses on query happen often.
    logic [31:0] value_pool [POOL_SIZE];

    int          idle_pct = 0;
    int          error_count = 0;
    int          results_checked = 0;
    int          commands_sent = 0;
    int          status_seen [8];

    sorted_set_successor_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one command to the bench's copy of the set and returns the result the
    // block should produce for it. The duplicate check comes before the full check,
    // so a known value offered to a full table reads as a duplicate, not a refusal.
    function automatic t_out_item apply_set_command(input t_in_item cmd_item);
        t_out_item   res;
        logic [31:0] v;
        int          pos;
        int          i;
        res = '0;
        v   = cmd_item.item_value;
        // First entry that is not below the value; set_count when there is none.
        pos = 0;
        while (pos < set_count && set_vals[pos] < v)
            pos++;
        case (cmd_item.cmd)
            CMD_INSERT: begin
                if (pos < set_count && set_vals[pos] == v) begin
                    res.status = ST_DUP;
                end else if (set_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = set_count; i > pos; i--)
                        set_vals[i] = set_vals[i - 1];
                    set_vals[pos] = v;
                    set_count++;
                end
            end
            CMD_REMOVE: begin
                if (set_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos >= set_count || set_vals[pos] != v) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    for (i = pos; i + 1 < set_count; i++)
                        set_vals[i] = set_vals[i + 1];
                    set_count--;
                end
            end
            CMD_QUERY: begin
                // Strictly greater: an equal entry is skipped, and no larger entry gives zero.
                for (i = 0; i < set_count; i++) begin
                    if (set_vals[i] > v) begin
                        res.successor_value = set_vals[i];
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.entry_count = set_count[4:0];
        return res;
    endfunction

    // Sends one command transaction. Before it the sender may sit idle, with random
    // junk on the payload while start is low. The task returns in the time step of
    // the accepting edge with start still high, so a following call that does not
    // idle first keeps start asserted without lowering it in between.
    task automatic send_command(input logic [1:0] cmd, input logic [31:0] value);
        t_in_item cmd_item;
        cmd_item.cmd        = cmd;
        cmd_item.item_value = value;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start             <= 1'b0;
            i_item.cmd        <= 2'($urandom_range(0, 3));
            i_item.item_value <= $urandom;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd_item;
        // The transaction is taken at the first edge that sees busy low.
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_results.push_back(apply_set_command(cmd_item));
        commands_sent++;
        if (set_count > peak_count)
            peak_count = set_count;
    endtask

    // Every result is checked at the edge that ends its strobe cycle, against the
    // oldest expectation. An X on the strobe counts as a result and so cannot slip by.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done !== 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no command outstanding: successor_value %0h, status %0d, entry_count %0d",
                       o_result.successor_value, o_result.status, o_result.entry_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.successor_value !== want.successor_value) begin
                    $error("successor_value: expected %0h, got %0h",
                           want.successor_value, o_result.successor_value);
                    error_count++;
                end
                if (o_result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_result.status);
                    error_count++;
                end
                if (o_result.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, o_result.entry_count);
                    error_count++;
                end
                results_checked++;
                status_seen[want.status]++;
            end
        end
    end

    // An empty set: nothing to remove, nothing above any value, and the spare code.
    task automatic test_empty_set();
        send_command(CMD_QUERY, 32'h0000_0000);
        send_command(CMD_REMOVE, 32'h0000_0005);
        send_command(CMD_UNUSED, 32'hA5A5_A5A5);
    endtask

    // The smallest and largest values, a duplicate, a query that finds nothing above
    // the top value, a remove that misses, and a query just below the middle value.
    task automatic test_extreme_values();
        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_QUERY, 32'h0000_0000);
        send_command(CMD_QUERY, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 32'h0000_0007);
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_QUERY, 32'h7FFF_FFFF);
    endtask

    // Fill the table to capacity, then offer a new value (refused as full) and a
    // stored one (reported as a duplicate), query inside the full chain and send the spare code.
    task automatic test_full_table();
        int k;
        k = 0;
        while (set_count < CAPACITY) begin
            send_command(CMD_INSERT, 32'h1000_0000 + k * 32'h0100_0000);
            k++;
        end
        send_command(CMD_INSERT, 32'h0000_0005);
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_QUERY, 32'h1000_0000);
        send_command(CMD_UNUSED, 32'h5A5A_5A5A);
    endtask

    // Random traffic. insert_pct steers the set toward full or toward empty, so that
    // the phases cross every occupancy. Values come mostly from a small pool and from
    // the stored entries and their neighbors, with extremes and fully random values mixed in.
    task automatic test_random_traffic(input int n_items, input int sender_idle_pct,
                                       input int insert_pct);
        int          n;
        int          sel;
        logic [1:0]  cmd;
        logic [31:0] v;
        idle_pct = sender_idle_pct;
        for (n = 0; n < POOL_SIZE; n++)
            value_pool[n] = (n < POOL_SIZE / 2) ? $urandom_range(0, 31) : $urandom;
        for (n = 0; n < n_items; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 3)
                cmd = CMD_UNUSED;
            else if (sel < 3 + insert_pct)
                cmd = CMD_INSERT;
            else if (sel < 3 + insert_pct + (97 - insert_pct) / 2)
                cmd = CMD_REMOVE;
            else
                cmd = CMD_QUERY;

            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            end else if (sel < 65 && set_count > 0) begin
                // A stored value, or one just below or above it (wrapping at the ends).
                v = set_vals[$urandom_range(0, set_count - 1)] + $urandom_range(0, 2) - 1;
            end else if (sel < 75) begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'hFFFF_FFFF;
                    2:       v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end else begin
                v = $urandom;
            end
            send_command(cmd, v);
        end
    endtask

    // Main sequence: reset once, directed tests back to back, then random phases
    // under different sender idling, then drain and report.
    initial begin
        int wait_cycles;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_set();
        test_extreme_values();
        test_full_table();

        // Starting full, the first phase drains the set, the second refills it while
        // the sender is mostly idle, and the last two wander around the middle.
        test_random_traffic(300, 0, 25);
        test_random_traffic(300, 82, 65);
        test_random_traffic(300, 18, 45);
        test_random_traffic(300, 0, 48);

        start <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 200) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        // Further edges catch any stray strobe after the last result.
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end

        $display("Checked %0d of %0d command transactions: ok %0d, duplicate %0d, not found %0d, empty %0d, full %0d.",
                 results_checked, commands_sent, status_seen[ST_OK], status_seen[ST_DUP],
                 status_seen[ST_NOTFOUND], status_seen[ST_EMPTY], status_seen[ST_FULL]);
        $display("Occupancy reached %0d of %0d entries; sender idling ran at 0, 82 and 18 percent.",
                 peak_count, CAPACITY);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: ends the run as a failure if it has not finished by this time.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_set_successor_table.sv
tb/sv/tb_sorted_set_successor_table.sv
